>>> sv/tlm_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and phase tables for the traffic light controller.
// No dependencies; used by tlm_phase_logic and traffic_light_moore_fsm.
package tlm_pkg;

    localparam int SENSOR_W      = 3;
    localparam int DWELL_W       = 8;
    localparam int LAMP_W        = 6;
    localparam int PHASE_W       = 4;
    localparam int CFG_INDEX_W   = 1;
    localparam int S_TDATA_W     = 8;
    localparam int M_TDATA_W     = 16;

    localparam logic [DWELL_W-1:0] TRAFFIC_DWELL_RESET = 8'd100;
    localparam logic [DWELL_W-1:0] WALK_DWELL_RESET    = 8'd50;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TRAFFIC_DWELL = 1'd0,
        REG_WALK_DWELL    = 1'd1
    } cfg_reg_t;

    typedef enum logic [PHASE_W-1:0] {
        PH_GO_WEST         = 4'd0,
        PH_WAIT_WEST       = 4'd1,
        PH_GO_SOUTH        = 4'd2,
        PH_WAIT_SOUTH      = 4'd3,
        PH_WALK            = 4'd4,
        PH_DONT_WALK       = 4'd5,
        PH_WALK_OFF        = 4'd6,
        PH_FLASH_DONT_WALK = 4'd7,
        PH_FLASH_WALK_OFF  = 4'd8
    } phase_t;

    localparam logic [LAMP_W-1:0] LAMPS_GO_WEST    = 6'h0C;
    localparam logic [LAMP_W-1:0] LAMPS_WAIT_WEST  = 6'h14;
    localparam logic [LAMP_W-1:0] LAMPS_GO_SOUTH   = 6'h21;
    localparam logic [LAMP_W-1:0] LAMPS_WAIT_SOUTH = 6'h22;
    localparam logic [LAMP_W-1:0] LAMPS_ALL_RED    = 6'h24;

    typedef struct packed {
        logic [LAMP_W-1:0] traffic_lamps;
        logic              walk_on;
        logic              dont_walk_on;
        phase_t            phase_index;
        logic              phase_changed;
    } result_t;

    // Next phase for each current phase, indexed by the three detector bits.
    localparam phase_t NEXT_TABLE [9][8] = '{
        '{PH_GO_WEST, PH_GO_WEST, PH_WAIT_WEST, PH_WAIT_WEST,
          PH_WAIT_WEST, PH_WAIT_WEST, PH_WAIT_WEST, PH_WAIT_WEST},
        '{PH_GO_WEST, PH_GO_WEST, PH_GO_SOUTH, PH_GO_SOUTH,
          PH_WALK, PH_WALK, PH_GO_SOUTH, PH_GO_SOUTH},
        '{PH_GO_SOUTH, PH_WAIT_SOUTH, PH_GO_SOUTH, PH_WAIT_SOUTH,
          PH_WAIT_SOUTH, PH_WAIT_SOUTH, PH_WAIT_SOUTH, PH_WAIT_SOUTH},
        '{PH_GO_SOUTH, PH_GO_WEST, PH_GO_SOUTH, PH_GO_WEST,
          PH_WALK, PH_WALK, PH_WALK, PH_WALK},
        '{PH_WALK, PH_DONT_WALK, PH_DONT_WALK, PH_DONT_WALK,
          PH_WALK, PH_DONT_WALK, PH_DONT_WALK, PH_DONT_WALK},
        '{PH_DONT_WALK, PH_WALK_OFF, PH_WALK_OFF, PH_WALK_OFF,
          PH_WALK_OFF, PH_WALK_OFF, PH_WALK_OFF, PH_WALK_OFF},
        '{PH_WALK_OFF, PH_FLASH_DONT_WALK, PH_FLASH_DONT_WALK, PH_FLASH_DONT_WALK,
          PH_FLASH_DONT_WALK, PH_FLASH_DONT_WALK, PH_FLASH_DONT_WALK,
          PH_FLASH_DONT_WALK},
        '{PH_FLASH_DONT_WALK, PH_FLASH_WALK_OFF, PH_FLASH_WALK_OFF,
          PH_FLASH_WALK_OFF, PH_FLASH_WALK_OFF, PH_FLASH_WALK_OFF,
          PH_FLASH_WALK_OFF, PH_FLASH_WALK_OFF},
        '{PH_FLASH_WALK_OFF, PH_GO_WEST, PH_GO_SOUTH, PH_GO_WEST,
          PH_WALK, PH_GO_WEST, PH_GO_SOUTH, PH_GO_WEST}
    };

    function automatic phase_t next_phase(input phase_t phase,
                                          input logic [SENSOR_W-1:0] sensors);
        phase_t result;
        case (phase)
            PH_GO_WEST:         result = NEXT_TABLE[0][sensors];
            PH_WAIT_WEST:       result = NEXT_TABLE[1][sensors];
            PH_GO_SOUTH:        result = NEXT_TABLE[2][sensors];
            PH_WAIT_SOUTH:      result = NEXT_TABLE[3][sensors];
            PH_WALK:            result = NEXT_TABLE[4][sensors];
            PH_DONT_WALK:       result = NEXT_TABLE[5][sensors];
            PH_WALK_OFF:        result = NEXT_TABLE[6][sensors];
            PH_FLASH_DONT_WALK: result = NEXT_TABLE[7][sensors];
            PH_FLASH_WALK_OFF:  result = NEXT_TABLE[8][sensors];
            default:            result = NEXT_TABLE[0][sensors];
        endcase
        return result;
    endfunction

    function automatic logic [LAMP_W-1:0] phase_lamps(input phase_t phase);
        logic [LAMP_W-1:0] result;
        case (phase)
            PH_GO_WEST:    result = LAMPS_GO_WEST;
            PH_WAIT_WEST:  result = LAMPS_WAIT_WEST;
            PH_GO_SOUTH:   result = LAMPS_GO_SOUTH;
            PH_WAIT_SOUTH: result = LAMPS_WAIT_SOUTH;
            default:       result = LAMPS_ALL_RED;
        endcase
        return result;
    endfunction

    function automatic logic is_traffic_phase(input phase_t phase);
        logic result;
        case (phase)
            PH_GO_WEST, PH_WAIT_WEST, PH_GO_SOUTH, PH_WAIT_SOUTH: result = 1'b1;
            PH_WALK, PH_DONT_WALK, PH_WALK_OFF,
            PH_FLASH_DONT_WALK, PH_FLASH_WALK_OFF:                result = 1'b0;
            default:                                              result = 1'b1;
        endcase
        return result;
    endfunction

endpackage

>>> sv/traffic_light_moore_fsm.sv
`timescale 1ns / 1ps
// Top level of the nine-phase Moore traffic light controller with a pedestrian
// phase. Depends on tlm_pkg and tlm_phase_logic.
//
// Usage: each item on the s_ channel is one 10 ms tick carrying the three
// detector bits. Each accepted tick yields exactly one item on the m_ channel
// with the lamp pattern of the phase held after the tick, the walk and
// don't-walk lamps, the phase number and a flag that is set when the tick
// ended the dwell time and took a table step, which may keep the same phase.
// The cfg_ channel writes the two dwell registers: index 0 sets the traffic
// dwell, index 1 the pedestrian dwell. It is always ready and should be used
// only while no tick is in flight.
// The result of an accepted tick is registered and drives m_tdata, and a tick
// can be taken every cycle while the receiver does not stall; the phase and
// dwell counter registers update in the same cycle that the result register loads.
// While the receiver stalls, the result is held and s_tready stays low until
// the result is taken; s_tready rises again in the cycle it is taken.
// Reset puts the machine in go west with the dwell counter at zero, loads the
// dwell registers with 100 and 50 ticks and clears the result valid flag.
module traffic_light_moore_fsm
    import tlm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,   // [2:0] sensors, [7:3] zero
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata,   // [5:0] traffic_lamps, [6] walk_on,
                                              // [7] dont_walk_on, [11:8] phase_index,
                                              // [12] phase_changed, [15:13] zero
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [DWELL_W-1:0]     cfg_data
);

    phase_t             phase_reg;
    phase_t             phase_next;
    logic [DWELL_W-1:0] dwell_count_reg;
    logic [DWELL_W-1:0] dwell_count_next;
    logic [DWELL_W-1:0] traffic_dwell_reg;
    logic [DWELL_W-1:0] walk_dwell_reg;
    result_t            result_next;
    result_t            result_reg;
    logic               out_valid_reg;
    logic               accept;

    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    tlm_phase_logic u_phase_logic (
        .phase            (phase_reg),
        .dwell_count      (dwell_count_reg),
        .sensors          (s_tdata[SENSOR_W-1:0]),
        .traffic_dwell    (traffic_dwell_reg),
        .walk_dwell       (walk_dwell_reg),
        .phase_next       (phase_next),
        .dwell_count_next (dwell_count_next),
        .result           (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            traffic_dwell_reg <= TRAFFIC_DWELL_RESET;
            walk_dwell_reg    <= WALK_DWELL_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_TRAFFIC_DWELL: traffic_dwell_reg <= cfg_data;
                REG_WALK_DWELL:    walk_dwell_reg    <= cfg_data;
                default:           traffic_dwell_reg <= traffic_dwell_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_GO_WEST;
            dwell_count_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg       <= phase_next;
                dwell_count_reg <= dwell_count_next;
                out_valid_reg   <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000,
                       result_reg.phase_changed,
                       result_reg.phase_index,
                       result_reg.dont_walk_on,
                       result_reg.walk_on,
                       result_reg.traffic_lamps};

endmodule

>>> sv/tlm_phase_logic.sv
`timescale 1ns / 1ps
// Combinational step of the phase machine: dwell check, table transition and
// Moore lamp decode of the phase held after the step. Depends on tlm_pkg.
module tlm_phase_logic
    import tlm_pkg::*;
(
    input  phase_t               phase,
    input  logic [DWELL_W-1:0]   dwell_count,
    input  logic [SENSOR_W-1:0]  sensors,
    input  logic [DWELL_W-1:0]   traffic_dwell,
    input  logic [DWELL_W-1:0]   walk_dwell,
    output phase_t               phase_next,
    output logic [DWELL_W-1:0]   dwell_count_next,
    output result_t              result
);

    logic [DWELL_W-1:0] dwell;
    logic [DWELL_W:0]   count_inc;
    logic               dwell_done;

    always_comb
    begin
        dwell      = is_traffic_phase(phase) ? traffic_dwell : walk_dwell;
        count_inc  = {1'b0, dwell_count} + {{DWELL_W{1'b0}}, 1'b1};
        dwell_done = (count_inc >= {1'b0, dwell});
        if (dwell_done)
        begin
            phase_next       = next_phase(phase, sensors);
            dwell_count_next = '0;
        end
        else
        begin
            phase_next       = (phase <= PH_FLASH_WALK_OFF) ? phase : PH_GO_WEST;
            dwell_count_next = count_inc[DWELL_W-1:0];
        end
    end

    always_comb
    begin
        result.traffic_lamps = phase_lamps(phase_next);
        result.walk_on       = (phase_next == PH_WALK);
        result.dont_walk_on  = !(phase_next == PH_WALK || phase_next == PH_WALK_OFF
                                 || phase_next == PH_FLASH_WALK_OFF);
        result.phase_index   = phase_next;
        result.phase_changed = dwell_done;
    end

endmodule
